>>> sv/l4hx_pkg.sv
// Shared types and constants for the Ethernet/IPv4 transport header extractor.
package l4hx_pkg;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [7:0]  PROTO_TCP = 8'h06;
  localparam logic [7:0]  PROTO_UDP = 8'h11;
  localparam logic [7:0]  ETH_HDR_LEN = 8'd14;
  localparam logic [7:0]  VLAN_HDR_LEN = 8'd18;
  localparam logic [3:0]  IP_MIN_WORDS = 4'd5;
  localparam logic [8:0]  IP_MIN_LEN = 9'd20;
  localparam logic [8:0]  UDP_PORT_BYTES = 9'd4;
  localparam logic [8:0]  TCP_OFFSET_BYTES = 9'd13;
  localparam logic [17:0] UDP_HDR_LEN = 18'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd1;
  localparam logic [2:0] ST_SHORT_IP  = 3'd2;
  localparam logic [2:0] ST_NOT_L4    = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_UNDERFLOW = 3'd5;

  typedef struct packed {
    logic [7:0]  byte_offset;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
    logic [3:0]  ip_header_words;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port_reg;
    logic [15:0] dest_port_reg;
    logic [3:0]  tcp_offset_words;
  } frame_state_t;

endpackage

>>> sv/l4hx_in_if.sv
// Byte stream channel carrying frame bytes with an end-of-frame mark.
interface l4hx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/l4hx_out_if.sv
// Summary channel carrying one header summary per frame.
interface l4hx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_udp;
  logic        vlan_tagged;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] payload_len;

  modport source (output valid, output status, output is_udp, output vlan_tagged,
                  output src_addr, output dst_addr, output src_port, output dst_port,
                  output payload_len, input ready);
  modport sink (input valid, input status, input is_udp, input vlan_tagged,
                input src_addr, input dst_addr, input src_port, input dst_port,
                input payload_len, output ready);
endinterface

>>> sv/l4hx_capture.sv
// Per-byte field capture with a snapshot register for the finished frame.
module l4hx_capture (
  input  logic                   clk,
  input  logic                   rst,
  l4hx_in_if.sink                frame,
  output logic                   snap_valid,
  input  logic                   snap_ready,
  output l4hx_pkg::frame_state_t snap
);
  import l4hx_pkg::*;

  frame_state_t st;
  frame_state_t st_next;
  frame_state_t snap_next;
  logic         accept;

  assign frame.ready = !snap_valid || snap_ready;
  assign accept = frame.valid && frame.ready;

  always_comb begin
    logic [7:0] o;
    logic [7:0] b;
    logic [7:0] s;
    logic [7:0] r;
    logic [7:0] l4;
    logic [7:0] q;
    o = st.byte_offset;
    b = frame.data_byte;
    s = ETH_HDR_LEN;
    r = '0;
    l4 = '0;
    q = '0;
    st_next = st;
    if (o != 8'hFF) begin
      st_next.byte_offset = o + 8'd1;
    end
    if (o == 8'd12) st_next.outer_type[15:8] = b;
    if (o == 8'd13) st_next.outer_type[7:0] = b;
    if (o >= ETH_HDR_LEN) begin
      if (st.outer_type == TYPE_VLAN) begin
        s = VLAN_HDR_LEN;
        if (o == 8'd16) st_next.inner_type[15:8] = b;
        if (o == 8'd17) st_next.inner_type[7:0] = b;
      end
      if (o >= s) begin
        r = o - s;
        if (r == 8'd0) st_next.ip_header_words = b[3:0];
        if (r == 8'd2) st_next.ip_total_length[15:8] = b;
        if (r == 8'd3) st_next.ip_total_length[7:0] = b;
        if (r == 8'd9) st_next.ip_protocol = b;
        if (r >= 8'd12 && r <= 8'd15) begin
          st_next.source_address = {st.source_address[23:0], b};
        end
        if (r >= 8'd16 && r <= 8'd19) begin
          st_next.dest_address = {st.dest_address[23:0], b};
        end
        if (r != 8'd0 && st.ip_header_words >= IP_MIN_WORDS) begin
          l4 = s + {2'b00, st.ip_header_words, 2'b00};
          if (o >= l4) begin
            q = o - l4;
            if (q == 8'd0) st_next.source_port_reg[15:8] = b;
            if (q == 8'd1) st_next.source_port_reg[7:0] = b;
            if (q == 8'd2) st_next.dest_port_reg[15:8] = b;
            if (q == 8'd3) st_next.dest_port_reg[7:0] = b;
            if (q == 8'd12) st_next.tcp_offset_words = b[7:4];
          end
        end
      end
    end
    snap_next = st_next;
    snap_next.byte_offset = st.byte_offset;
  end

  // The snapshot keeps the offset of the final byte, so the frame length is one more.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (frame.last_byte) begin
          st <= '0;
          snap <= snap_next;
          snap_valid <= 1'b1;
        end else begin
          st <= st_next;
          if (snap_ready) snap_valid <= 1'b0;
        end
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end
endmodule

>>> sv/l4hx_summary.sv
// Frame summary decision and the registered result stage.
module l4hx_summary (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   snap_valid,
  output logic                   snap_ready,
  input  l4hx_pkg::frame_state_t snap,
  l4hx_out_if.source             summary
);
  import l4hx_pkg::*;

  logic        out_valid;
  logic [2:0]  status;
  logic        is_udp;
  logic        vlan_tagged;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] payload_len;

  logic [2:0]  status_next;
  logic        is_udp_next;
  logic        vlan_next;
  logic [31:0] src_addr_next;
  logic [31:0] dst_addr_next;
  logic [15:0] src_port_next;
  logic [15:0] dst_port_next;
  logic [15:0] payload_len_next;

  assign snap_ready = !out_valid || summary.ready;

  always_comb begin
    logic [8:0]  len;
    logic [8:0]  s;
    logic [8:0]  ip_hdr;
    logic [8:0]  need;
    logic        vlan;
    logic        udp;
    logic [17:0] pay;
    len = {1'b0, snap.byte_offset} + 9'd1;
    vlan = (snap.outer_type == TYPE_VLAN);
    udp = (snap.ip_protocol == PROTO_UDP);
    s = vlan ? {1'b0, VLAN_HDR_LEN} : {1'b0, ETH_HDR_LEN};
    ip_hdr = {3'b000, snap.ip_header_words, 2'b00};
    need = s + ip_hdr + (udp ? UDP_PORT_BYTES : TCP_OFFSET_BYTES);
    pay = {2'b00, snap.ip_total_length} - {9'd0, ip_hdr}
          - (udp ? UDP_HDR_LEN : {12'd0, snap.tcp_offset_words, 2'b00});
    status_next = ST_OK;
    is_udp_next = 1'b0;
    vlan_next = 1'b0;
    src_addr_next = '0;
    dst_addr_next = '0;
    src_port_next = '0;
    dst_port_next = '0;
    payload_len_next = '0;
    if (len < {1'b0, ETH_HDR_LEN}) begin
      status_next = ST_TRUNC;
    end else begin
      vlan_next = vlan;
      if (vlan && len < {1'b0, VLAN_HDR_LEN}) begin
        status_next = ST_TRUNC;
      end else if (!(snap.outer_type == TYPE_IPV4 ||
                     (vlan && snap.inner_type == TYPE_IPV4))) begin
        status_next = ST_NOT_IPV4;
      end else if (len < s + 9'd1) begin
        status_next = ST_TRUNC;
      end else if (snap.ip_header_words < IP_MIN_WORDS) begin
        status_next = ST_SHORT_IP;
      end else if (len < s + IP_MIN_LEN) begin
        status_next = ST_TRUNC;
      end else if (snap.ip_protocol != PROTO_TCP && !udp) begin
        status_next = ST_NOT_L4;
        src_addr_next = snap.source_address;
        dst_addr_next = snap.dest_address;
      end else if (len < need) begin
        status_next = ST_TRUNC;
      end else begin
        src_addr_next = snap.source_address;
        dst_addr_next = snap.dest_address;
        is_udp_next = udp;
        src_port_next = snap.source_port_reg;
        dst_port_next = snap.dest_port_reg;
        if (pay[17]) begin
          status_next = ST_UNDERFLOW;
        end else begin
          payload_len_next = pay[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      out_valid <= 1'b1;
    end else if (summary.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      status <= status_next;
      is_udp <= is_udp_next;
      vlan_tagged <= vlan_next;
      src_addr <= src_addr_next;
      dst_addr <= dst_addr_next;
      src_port <= src_port_next;
      dst_port <= dst_port_next;
      payload_len <= payload_len_next;
    end
  end

  assign summary.valid = out_valid;
  assign summary.status = status;
  assign summary.is_udp = is_udp;
  assign summary.vlan_tagged = vlan_tagged;
  assign summary.src_addr = src_addr;
  assign summary.dst_addr = dst_addr;
  assign summary.src_port = src_port;
  assign summary.dst_port = dst_port;
  assign summary.payload_len = payload_len;
endmodule

>>> sv/ipv4_l4_header_extractor_unit.sv
// Top level of the Ethernet/VLAN/IPv4 transport header extractor.
// Throughput: one frame byte per cycle; a byte is taken in every cycle unless a summary stalls.
// After the final byte transfers, its summary passes the snapshot register and then the result register.
// The snapshot register and the result register each hold one finished frame.
// Reset clears the captured header fields, the byte offset and both valid flags.
module ipv4_l4_header_extractor_unit (
  input logic        clk,
  input logic        rst,
  l4hx_in_if.sink    frame,
  l4hx_out_if.source summary
);
  import l4hx_pkg::*;

  logic         snap_valid;
  logic         snap_ready;
  frame_state_t snap;

  l4hx_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  l4hx_summary u_summary (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .summary    (summary)
  );

`ifndef ASSERT_OFF
  a_last_makes_snapshot: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && frame.last_byte) |=> snap_valid)
    else $error("Final byte transfer did not produce a snapshot.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    summary.valid |-> (summary.status <= ST_UNDERFLOW))
    else $error("Summary status code out of range.");

  a_ports_only_when_l4: assert property (@(posedge clk) disable iff (rst)
    (summary.valid && summary.status != ST_OK && summary.status != ST_UNDERFLOW) |->
    (!summary.is_udp && summary.src_port == 16'd0 && summary.dst_port == 16'd0))
    else $error("Transport fields set on a frame without a transport header.");

  a_underflow_zero_len: assert property (@(posedge clk) disable iff (rst)
    (summary.valid && summary.status == ST_UNDERFLOW) |-> (summary.payload_len == 16'd0))
    else $error("Underflow summary carries a non-zero payload length.");
`endif
endmodule

>>> tb/l4hx_summary_checker.sv
// Checker that predicts the header summary of each frame and compares it with the block's output.
module l4hx_summary_checker (
  input  logic        clk,
  input  logic        rst,
  l4hx_in_if          frame,
  l4hx_out_if         summary,
  output int unsigned errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import l4hx_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_udp;
    logic        vlan_tagged;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
  } summary_t;

  frame_state_t hdr;
  summary_t     expected_summaries[$];

  function automatic int ip_offset();
    return (hdr.outer_type == TYPE_VLAN) ? int'(VLAN_HDR_LEN) : int'(ETH_HDR_LEN);
  endfunction

  task automatic capture_byte(input logic [7:0] b);
    int o, s, r, l4, q;
    o = int'(hdr.byte_offset);
    if (o == 12) hdr.outer_type[15:8] = b;
    if (o == 13) hdr.outer_type[7:0] = b;
    if (o < int'(ETH_HDR_LEN)) return;
    if (hdr.outer_type == TYPE_VLAN) begin
      if (o == 16) hdr.inner_type[15:8] = b;
      if (o == 17) hdr.inner_type[7:0] = b;
    end
    s = ip_offset();
    if (o < s) return;
    r = o - s;
    if (r == 0) hdr.ip_header_words = b[3:0];
    if (r == 2) hdr.ip_total_length[15:8] = b;
    if (r == 3) hdr.ip_total_length[7:0] = b;
    if (r == 9) hdr.ip_protocol = b;
    if (r >= 12 && r <= 15) hdr.source_address = {hdr.source_address[23:0], b};
    if (r >= 16 && r <= 19) hdr.dest_address = {hdr.dest_address[23:0], b};
    if (r == 0 || hdr.ip_header_words < IP_MIN_WORDS) return;
    l4 = s + 4 * int'(hdr.ip_header_words);
    if (o < l4) return;
    q = o - l4;
    if (q == 0) hdr.source_port_reg[15:8] = b;
    if (q == 1) hdr.source_port_reg[7:0] = b;
    if (q == 2) hdr.dest_port_reg[15:8] = b;
    if (q == 3) hdr.dest_port_reg[7:0] = b;
    if (q == 12) hdr.tcp_offset_words = b[7:4];
  endtask

  function automatic summary_t predict_summary();
    summary_t res;
    int       len, s, l4, need, tl_hdr, pay;
    logic     udp;
    res = '0;
    len = int'(hdr.byte_offset) + 1;
    if (len < int'(ETH_HDR_LEN)) begin
      res.status = ST_TRUNC;
      return res;
    end
    res.vlan_tagged = (hdr.outer_type == TYPE_VLAN);
    s = ip_offset();
    if (res.vlan_tagged && len < s) begin
      res.status = ST_TRUNC;
      return res;
    end
    if (!(hdr.outer_type == TYPE_IPV4 || (res.vlan_tagged && hdr.inner_type == TYPE_IPV4)))
    begin
      res.status = ST_NOT_IPV4;
      return res;
    end
    if (len < s + 1) begin
      res.status = ST_TRUNC;
      return res;
    end
    if (hdr.ip_header_words < IP_MIN_WORDS) begin
      res.status = ST_SHORT_IP;
      return res;
    end
    if (len < s + int'(IP_MIN_LEN)) begin
      res.status = ST_TRUNC;
      return res;
    end
    res.src_addr = hdr.source_address;
    res.dst_addr = hdr.dest_address;
    if (hdr.ip_protocol != PROTO_TCP && hdr.ip_protocol != PROTO_UDP) begin
      res.status = ST_NOT_L4;
      return res;
    end
    udp = (hdr.ip_protocol == PROTO_UDP);
    l4 = s + 4 * int'(hdr.ip_header_words);
    need = l4 + (udp ? int'(UDP_PORT_BYTES) : int'(TCP_OFFSET_BYTES));
    if (len < need) begin
      res.status = ST_TRUNC;
      res.src_addr = '0;
      res.dst_addr = '0;
      return res;
    end
    res.is_udp = udp;
    res.src_port = hdr.source_port_reg;
    res.dst_port = hdr.dest_port_reg;
    tl_hdr = udp ? int'(UDP_HDR_LEN) : 4 * int'(hdr.tcp_offset_words);
    pay = int'(hdr.ip_total_length) - 4 * int'(hdr.ip_header_words) - tl_hdr;
    res.status = ST_OK;
    if (pay < 0) begin
      res.status = ST_UNDERFLOW;
      pay = 0;
    end
    res.payload_len = pay[15:0];
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t ns: summary %s mismatch, got %0h, expected %0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin : watch
    summary_t got, want;
    if (rst) begin
      hdr = '0;
      expected_summaries.delete();
      errors = 0;
    end else begin
      if (summary.valid && summary.ready) begin
        got.status      = summary.status;
        got.is_udp      = summary.is_udp;
        got.vlan_tagged = summary.vlan_tagged;
        got.src_addr    = summary.src_addr;
        got.dst_addr    = summary.dst_addr;
        got.src_port    = summary.src_port;
        got.dst_port    = summary.dst_port;
        got.payload_len = summary.payload_len;
        if (expected_summaries.size() == 0) begin
          report("unexpected transfer, status", got.status, '0);
        end else begin
          want = expected_summaries.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.is_udp !== want.is_udp) report("is_udp", got.is_udp, want.is_udp);
          if (got.vlan_tagged !== want.vlan_tagged)
            report("vlan_tagged", got.vlan_tagged, want.vlan_tagged);
          if (got.src_addr !== want.src_addr) report("src_addr", got.src_addr, want.src_addr);
          if (got.dst_addr !== want.dst_addr) report("dst_addr", got.dst_addr, want.dst_addr);
          if (got.src_port !== want.src_port) report("src_port", got.src_port, want.src_port);
          if (got.dst_port !== want.dst_port) report("dst_port", got.dst_port, want.dst_port);
          if (got.payload_len !== want.payload_len)
            report("payload_len", got.payload_len, want.payload_len);
        end
      end
      if (frame.valid && frame.ready) begin
        capture_byte(frame.data_byte);
        if (frame.last_byte) begin
          expected_summaries.push_back(predict_summary());
          hdr = '0;
        end else if (hdr.byte_offset != 8'hFF) begin
          hdr.byte_offset++;
        end
      end
    end
    pending = expected_summaries.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the testbench: clock, reset, frame stimulus, summary back-pressure and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import l4hx_pkg::*;

  localparam logic [15:0] TYPE_ARP   = 16'h0806;
  localparam logic [7:0]  PROTO_ICMP = 8'h01;
  localparam int          STALL_LIMIT = 3000;
  localparam int          LONG_HOLD   = 500;

  logic        clk;
  logic        rst;
  logic        in_took;
  logic        out_took;
  int unsigned errors;
  int          pending;

  logic [7:0]  frame_bytes[$];
  int          burst_left;
  bit          gaps_on;
  bit          hold_request;
  int          bytes_sent;
  int          rx_mode, rx_span, rx_tick;

  l4hx_in_if  frame_ch();
  l4hx_out_if summary_ch();

  ipv4_l4_header_extractor_unit u_dut (
    .clk(clk),
    .rst(rst),
    .frame(frame_ch),
    .summary(summary_ch)
  );

  l4hx_summary_checker u_checker (
    .clk(clk),
    .rst(rst),
    .frame(frame_ch),
    .summary(summary_ch),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_took  <= frame_ch.valid && frame_ch.ready;
    out_took <= summary_ch.valid && summary_ch.ready;
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_bytes(input logic [31:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) frame_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic push_random(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic build_frame(input logic [15:0] outer, input logic [15:0] inner,
                             input logic [3:0] ihl, input logic [7:0] proto,
                             input logic [3:0] doff, input logic [15:0] tot,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [15:0] sport, input logic [15:0] dport,
                             input int pay_n);
    frame_bytes.delete();
    push_random(12);
    push_bytes(outer, 2);
    if (outer == TYPE_VLAN) begin
      push_random(2);
      push_bytes(inner, 2);
    end
    frame_bytes.push_back({4'h4, ihl});
    push_random(1);
    push_bytes(tot, 2);
    push_random(5);
    frame_bytes.push_back(proto);
    push_random(2);
    push_bytes(src, 4);
    push_bytes(dst, 4);
    if (ihl > IP_MIN_WORDS) push_random(4 * (int'(ihl) - 5));
    push_bytes(sport, 2);
    push_bytes(dport, 2);
    if (proto == PROTO_UDP) begin
      push_random(4);
    end else begin
      push_random(8);
      frame_bytes.push_back({doff, 4'($urandom)});
      push_random(7);
      if (doff > 4'd5) push_random(4 * (int'(doff) - 5));
    end
    push_random(pay_n);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        frame_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    frame_ch.valid     <= 1'b1;
    frame_ch.data_byte <= b;
    frame_ch.last_byte <= l;
    do @(negedge clk); while (!in_took);
  endtask

  // A non-zero cut shorter than the frame ends it early at that many bytes.
  task automatic send_frame(input int cut);
    int i, n;
    n = frame_bytes.size();
    if (cut > 0 && cut < n) n = cut;
    for (i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
    bytes_sent += n;
  endtask

  task automatic drain();
    frame_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic random_frame();
    int         k, n, cut;
    logic [15:0] outer, inner, tot;
    logic [3:0]  ihl, doff;
    logic [7:0]  proto;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      frame_bytes.delete();
      push_random($urandom_range(1, 70));
      if (frame_bytes.size() > 13 && $urandom_range(0, 1)) begin
        frame_bytes[12] = TYPE_IPV4[15:8];
        frame_bytes[13] = TYPE_IPV4[7:0];
      end
      send_frame(0);
      return;
    end
    outer = ($urandom_range(0, 9) < 3) ? TYPE_VLAN : TYPE_IPV4;
    inner = TYPE_IPV4;
    if (k < 14) begin
      case ($urandom_range(0, 3))
        0: inner = TYPE_VLAN;
        1: inner = 16'($urandom);
        2: outer = 16'($urandom);
        default: outer = TYPE_ARP;
      endcase
      if (inner != TYPE_IPV4) outer = TYPE_VLAN;
    end
    k = $urandom_range(0, 99);
    if (k < 80) ihl = 4'd5;
    else if (k < 92) ihl = 4'($urandom_range(6, 15));
    else ihl = 4'($urandom_range(0, 4));
    k = $urandom_range(0, 99);
    if (k < 45) proto = PROTO_TCP;
    else if (k < 90) proto = PROTO_UDP;
    else proto = 8'($urandom);
    k = $urandom_range(0, 99);
    if (k < 80) doff = 4'd5;
    else if (k < 90) doff = 4'($urandom_range(6, 15));
    else doff = 4'($urandom_range(0, 4));
    n = ($urandom_range(0, 99) < 3) ? $urandom_range(200, 240) : $urandom_range(0, 16);
    k = $urandom_range(0, 99);
    if (k < 70)
      tot = 16'(4 * int'(ihl) + ((proto == PROTO_UDP) ? 8 : 4 * int'(doff)) + n);
    else if (k < 85) tot = 16'($urandom_range(0, 60));
    else tot = 16'($urandom);
    build_frame(outer, inner, ihl, proto, doff, tot, pick32(), pick32(),
                16'(pick32()), 16'(pick32()), n);
    cut = ($urandom_range(0, 99) < 15) ? $urandom_range(1, frame_bytes.size()) : 0;
    send_frame(cut);
  endtask

  initial begin
    int frames;
    rst <= 1'b1;
    frame_ch.valid     <= 1'b0;
    frame_ch.data_byte <= '0;
    frame_ch.last_byte <= 1'b0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_request = 1'b0;
    bytes_sent = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_TCP, 5, 44, 32'h0A000001, 32'hC0A80001,
                80, 443, 4);
    send_frame(0);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_UDP, 0, 34, 32'h01020304, 32'h05060708,
                53, 5353, 6);
    send_frame(0);
    build_frame(TYPE_VLAN, TYPE_IPV4, 5, PROTO_TCP, 5, 44, 32'h7F000001, 32'h08080808,
                1234, 22, 4);
    send_frame(0);
    build_frame(TYPE_VLAN, TYPE_IPV4, 5, PROTO_UDP, 0, 16'hFFFF, '1, '1, '1, '1, 3);
    send_frame(0);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_TCP, 5, 40, '0, '0, '0, '0, 0);
    send_frame(0);
    build_frame(TYPE_VLAN, TYPE_VLAN, 5, PROTO_TCP, 5, 40, '1, '1, 1, 2, 0);
    send_frame(0);
    build_frame(TYPE_VLAN, TYPE_ARP, 5, PROTO_TCP, 5, 40, '1, '1, 1, 2, 0);
    send_frame(0);
    build_frame(TYPE_ARP, TYPE_IPV4, 5, PROTO_UDP, 0, 28, '1, '1, 1, 2, 0);
    send_frame(0);
    send_frame(1);
    send_frame(13);
    build_frame(TYPE_VLAN, TYPE_IPV4, 5, PROTO_TCP, 5, 40, '1, '1, 1, 2, 0);
    send_frame(14);
    send_frame(17);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_TCP, 5, 40, '1, '1, 1, 2, 0);
    send_frame(14);
    send_frame(33);
    build_frame(TYPE_IPV4, TYPE_IPV4, 4, PROTO_TCP, 5, 40, '1, '1, 1, 2, 0);
    send_frame(0);
    build_frame(TYPE_IPV4, TYPE_IPV4, 0, PROTO_UDP, 5, 40, '1, '1, 1, 2, 0);
    send_frame(15);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_ICMP, 5, 40, 32'hA5A5A5A5, 32'h5A5A5A5A,
                1, 2, 4);
    send_frame(0);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_UDP, 0, 40, '1, '1, 7, 9, 4);
    send_frame(37);
    send_frame(38);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_TCP, 5, 44, '1, '1, 7, 9, 4);
    send_frame(46);
    send_frame(47);
    build_frame(TYPE_IPV4, TYPE_IPV4, 15, PROTO_TCP, 15, 125, 32'h80000001, 32'h00000080,
                16'h8001, 16'h0180, 5);
    send_frame(0);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_TCP, 2, 40, '1, '0, 1, 2, 12);
    send_frame(0);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_TCP, 5, 30, '1, '0, 1, 2, 0);
    send_frame(0);
    build_frame(TYPE_IPV4, TYPE_IPV4, 5, PROTO_UDP, 0, 288, '0, '1, 3, 4, 260);
    send_frame(0);
    build_frame(TYPE_VLAN, TYPE_IPV4, 6, PROTO_UDP, 0, 40, 32'h0B0C0D0E, 32'h0F101112,
                5, 6, 8);
    send_frame(0);
    drain();

    frames = 0;
    while (bytes_sent < 1350 || frames < 8) begin
      if (frames == 3) begin
        drain();
        hold_request = 1'b1;
      end
      if (frames >= 3 && frames < 6) gaps_on = 1'b0;
      else gaps_on = ($urandom_range(0, 3) != 0);
      if (frames == 6) drain();
      random_frame();
      frames++;
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // The summary side stalls in changing modes; on request it holds off for a long stretch.
  initial begin
    summary_ch.ready <= 1'b0;
    rx_mode = 0;
    rx_span = 0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        summary_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (rx_span == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_span = $urandom_range(20, 200);
        end
        rx_span--;
        case (rx_mode)
          0: summary_ch.ready <= 1'b1;
          1: summary_ch.ready <= ($urandom_range(0, 9) < 7);
          2: summary_ch.ready <= ($urandom_range(0, 3) == 0);
          default: summary_ch.ready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

>>> ipv4_l4_header_extractor_unit.f
sv/l4hx_pkg.sv
sv/l4hx_in_if.sv
sv/l4hx_out_if.sv
sv/l4hx_capture.sv
sv/l4hx_summary.sv
sv/ipv4_l4_header_extractor_unit.sv
tb/l4hx_summary_checker.sv
tb/testbench.sv
